// ----- sv/rlpl_pkg.sv -----
// rlpl_pkg: shared types, constants and helpers for the route lookup unit
// no dependencies; imported by rlpl_ctrl, rlpl_dp and the top level (rlpl_ram does not use it)
`default_nettype none

package rlpl_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // field widths
  localparam int ADDR_W     = 32;
  localparam int PREFIX_W   = 6;
  localparam int METRIC_W   = 32;
  localparam int REQ_W      = 2;
  localparam int IDX_W      = 4;
  localparam int OUT_SLOT_W = 4;

  localparam logic [PREFIX_W-1:0] PREFIX_MAX    = PREFIX_W'(ADDR_W);
  localparam logic [ADDR_W-1:0]   ADDR_ALL_ONES = '1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INVAL  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  // one stored route
  typedef struct packed {
    logic [ADDR_W-1:0]   dest;
    logic [PREFIX_W-1:0] prefix;
    logic [METRIC_W-1:0] metric;
    logic [ADDR_W-1:0]   gateway;
  } route_entry_t;

  localparam int ENTRY_W = $bits(route_entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic              capture;  // latch the request word
    logic              rd_en;    // read one table slot
    logic [SLOT_W-1:0] rd_addr;
    logic              commit;   // apply write or invalidate
  } rlpl_cmd_t;

  // contiguous high-bit mask, prefix already limited to 0..32
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] plen);
    prefix_mask = ~(ADDR_ALL_ONES >> plen);
  endfunction

endpackage

`default_nettype wire

// ----- sv/rlpl_ram.sv -----
// rlpl_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rlpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/rlpl_ctrl.sv -----
// rlpl_ctrl: sequencer for the route lookup unit, drives the table scan
// depends on rlpl_pkg
`default_nettype none

module rlpl_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rlpl_pkg::REQ_W-1:0] in_req_type,
  output logic                           busy,
  output logic                           out_valid,
  output rlpl_pkg::rlpl_cmd_t            cmd
);
  import rlpl_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              accept;

  assign accept = start && (state_r == S_IDLE);

  // next state and scan counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = (in_req_type == REQ_LOOKUP) ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // commands and handshake
  always_comb begin
    cmd.capture = accept;
    cmd.rd_en   = (state_r == S_SCAN);
    cmd.rd_addr = cnt_r;
    cmd.commit  = (state_r == S_RESP);
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cnt_r == LAST_SLOT) |=> (state_r == S_DRAIN))
    else $error("scan did not end after last slot");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("not busy after accepting a word");

endmodule

`default_nettype wire

// ----- sv/rlpl_dp.sv -----
// rlpl_dp: route table storage, match compare and best-route registers
// depends on rlpl_pkg and rlpl_ram
`default_nettype none

module rlpl_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rlpl_pkg::rlpl_cmd_t                 cmd,
  input  wire logic [rlpl_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic [rlpl_pkg::IDX_W-1:0]          in_slot_index,
  input  wire logic [rlpl_pkg::ADDR_W-1:0]         in_dest_addr,
  input  wire logic [rlpl_pkg::PREFIX_W-1:0]       in_prefix_len,
  input  wire logic [rlpl_pkg::METRIC_W-1:0]       in_route_metric,
  input  wire logic [rlpl_pkg::ADDR_W-1:0]         in_gateway_addr,
  input  wire logic [rlpl_pkg::ADDR_W-1:0]         in_query_addr,
  output logic                                     out_hit,
  output logic      [rlpl_pkg::OUT_SLOT_W-1:0]     out_best_slot,
  output logic      [rlpl_pkg::ADDR_W-1:0]         out_best_gateway,
  output logic      [rlpl_pkg::METRIC_W-1:0]       out_best_metric,
  output logic      [rlpl_pkg::PREFIX_W-1:0]       out_best_prefix
);
  import rlpl_pkg::*;

  // latched request word
  logic [REQ_W-1:0]  req_r;
  logic [SLOT_W-1:0] idx_r;
  logic              idx_ok_r;
  route_entry_t      wr_entry_r;
  logic [ADDR_W-1:0] query_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r              <= in_req_type;
      idx_r              <= SLOT_W'(in_slot_index);
      idx_ok_r           <= (32'(in_slot_index) < TABLE_DEPTH);
      wr_entry_r.dest    <= in_dest_addr;
      wr_entry_r.prefix  <= (in_prefix_len > PREFIX_MAX) ? PREFIX_MAX : in_prefix_len;
      wr_entry_r.metric  <= in_route_metric;
      wr_entry_r.gateway <= in_gateway_addr;
      query_r            <= in_query_addr;
    end
  end

  // table update strobes
  logic do_write, do_inval;
  assign do_write = cmd.commit && (req_r == REQ_WRITE) && idx_ok_r;
  assign do_inval = cmd.commit && (req_r == REQ_INVAL) && idx_ok_r;

  // route storage
  logic [ENTRY_W-1:0] rd_word;
  route_entry_t       rd_entry;

  rlpl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (do_write),
    .waddr(idx_r),
    .wdata(wr_entry_r),
    .re   (cmd.rd_en),
    .raddr(cmd.rd_addr),
    .rdata(rd_word)
  );

  assign rd_entry = route_entry_t'(rd_word);

  // per-slot valid bits
  logic [TABLE_DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_write) begin
      valid_r[idx_r] <= 1'b1;
    end else if (do_inval) begin
      valid_r[idx_r] <= 1'b0;
    end
  end

  // valid bit and slot number aligned with ram read data
  logic              eval_r;
  logic              valid_d_r;
  logic [SLOT_W-1:0] addr_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r <= 1'b0;
    end else begin
      eval_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      valid_d_r <= valid_r[cmd.rd_addr];
      addr_d_r  <= cmd.rd_addr;
    end
  end

  // compare against best so far
  logic              found_r;
  logic [SLOT_W-1:0] best_slot_r;
  route_entry_t      best_r;
  logic              match, better;

  always_comb begin
    match  = valid_d_r &&
             (((rd_entry.dest ^ query_r) & prefix_mask(rd_entry.prefix)) == '0);
    better = !found_r || (rd_entry.prefix > best_r.prefix) ||
             ((rd_entry.prefix == best_r.prefix) && (rd_entry.metric < best_r.metric));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.capture) begin
      found_r <= 1'b0;
    end else if (eval_r && match) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      best_slot_r <= '0;
      best_r      <= '0;
    end else if (eval_r && match && better) begin
      best_slot_r <= addr_d_r;
      best_r      <= rd_entry;
    end
  end

  // result word
  assign out_hit          = found_r;
  assign out_best_slot    = OUT_SLOT_W'(best_slot_r);
  assign out_best_gateway = best_r.gateway;
  assign out_best_metric  = best_r.metric;
  assign out_best_prefix  = best_r.prefix;

  // checks
  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!found_r && !cmd.capture && $past(cmd.capture)) |->
      (best_r == '0 && best_slot_r == '0))
    else $error("result not cleared on a new word");
  a_no_eval_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(eval_r && cmd.commit)) else $error("table commit during scan");
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> valid_r[$past(idx_r)]) else $error("write left slot invalid");

endmodule

`default_nettype wire

// ----- sv/route_longest_prefix_lookup_unit.sv -----
// route_longest_prefix_lookup_unit: top level of the ipv4 longest prefix route table
// depends on rlpl_pkg, rlpl_ctrl, rlpl_dp (which holds rlpl_ram)
//
// channel   direction  handshake                    word
// ------    ---------  ---------------------------  -------------------------------
// in_       input      start high while busy low    request type, slot, route, query
// out_      output     out_valid one-cycle strobe   hit, slot, gateway, metric, prefix
//
// write, invalidate and unused requests: result taken in the cycle after accept
// lookup: result taken in S_RESP after S_SCAN, which reads one table slot per cycle
//   through the single ram read port, and S_DRAIN, which compares the last slot read
// busy stays high from the cycle after accept through the result cycle
// reset (rst_n low, synchronous) clears all slot valid bits at once; no sweep
// the receiver cannot stall: each result is taken in its strobe cycle
`default_nettype none

module route_longest_prefix_lookup_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [rlpl_pkg::REQ_W-1:0]           in_req_type,
  input  wire logic [rlpl_pkg::IDX_W-1:0]           in_slot_index,
  input  wire logic [rlpl_pkg::ADDR_W-1:0]          in_dest_addr,
  input  wire logic [rlpl_pkg::PREFIX_W-1:0]        in_prefix_len,
  input  wire logic [rlpl_pkg::METRIC_W-1:0]        in_route_metric,
  input  wire logic [rlpl_pkg::ADDR_W-1:0]          in_gateway_addr,
  input  wire logic [rlpl_pkg::ADDR_W-1:0]          in_query_addr,
  output logic                                      out_valid,
  output logic                                      out_hit,
  output logic      [rlpl_pkg::OUT_SLOT_W-1:0]      out_best_slot,
  output logic      [rlpl_pkg::ADDR_W-1:0]          out_best_gateway,
  output logic      [rlpl_pkg::METRIC_W-1:0]        out_best_metric,
  output logic      [rlpl_pkg::PREFIX_W-1:0]        out_best_prefix
);
  import rlpl_pkg::*;

  rlpl_cmd_t cmd;

  // sequencer
  rlpl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_req_type(in_req_type),
    .busy       (busy),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  // table and compare datapath
  rlpl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_slot_index   (in_slot_index),
    .in_dest_addr    (in_dest_addr),
    .in_prefix_len   (in_prefix_len),
    .in_route_metric (in_route_metric),
    .in_gateway_addr (in_gateway_addr),
    .in_query_addr   (in_query_addr),
    .out_hit         (out_hit),
    .out_best_slot   (out_best_slot),
    .out_best_gateway(out_best_gateway),
    .out_best_metric (out_best_metric),
    .out_best_prefix (out_best_prefix)
  );

endmodule

`default_nettype wire
